>>> sv/bus_event_packetizer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bus event packetizer
// Shorthand for clocked implication checks, sampled on clk_i with rst_ni low
// masking the check.
// ----------------------------------------------------------------------------
`ifndef BUS_EVENT_PACKETIZER_CORE_ASSERT_SVH
`define BUS_EVENT_PACKETIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BEP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bep_pkg.sv
// ----------------------------------------------------------------------------
// Bus event packetizer package
// Beat types, opcodes, header flags and the command passed from front to back.
// ----------------------------------------------------------------------------
package bep_pkg;

  localparam int unsigned MAX_EVENTS = 16;
  // Event count field of the command, sized for the largest packet supported.
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned EVT_W      = 16;

  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_DISCARD = 2'd2;

  localparam logic REG_CHANNEL = 1'b0;
  localparam logic REG_STOP    = 1'b1;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  localparam logic [7:0] FLAG_CONTINUED = 8'h01;
  localparam logic [7:0] FLAG_END       = 8'h02;
  localparam logic [7:0] FLAG_OVERFLOW  = 8'h04;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  event_kind;
    logic [7:0]  event_data;
    logic [7:0]  mark_bits;
    logic [31:0] time_now;
    logic        sink_ready;
  } bep_in_t;

  typedef struct packed {
    logic        item_kind;
    logic        last;
    logic [31:0] seq_number;
    logic [7:0]  header_flags;
    logic [7:0]  channel_out;
    logic [4:0]  events_in_packet;
    logic [31:0] packet_time;
    logic [7:0]  out_event_kind;
    logic [7:0]  out_event_data;
  } bep_out_t;

  // One flush request: header fields plus the buffer bank holding the events.
  typedef struct packed {
    logic             bank;
    logic [31:0]      seq;
    logic [7:0]       flags;
    logic [7:0]       channel;
    logic [CNT_W-1:0] count;
    logic [31:0]      stamp;
  } bep_cmd_t;

  // Back end hands a bank back once its last payload beat has gone out.
  typedef struct packed {
    logic valid;
    logic bank;
  } bep_release_t;

  function automatic int unsigned bep_idx_w(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

>>> sv/bus_event_packetizer_core.sv
// ----------------------------------------------------------------------------
// Bus event packetizer core
// Packs decoded bus events into sequenced, time-stamped packets of at most
// MaxEvents events, one header beat followed by one beat per event.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Beat
//  in       sink       in_valid_i/in_ready_o  bep_in_t: opcode, event, marks, time
//  out      source     out_valid_o/out_ready_i bep_out_t: header or payload event
//  cfg      sink       cfg_we_i (no stall)    cfg_idx_i selects channel/stop code
//
//  Mark, discard and unused opcodes leave the front end idle and ready.
//  An append passes the write state, and a push state too when it flushes
//  (neither when the sink refuses a full packet), and may wait there for a
//  free buffer bank or a free slot in the two-entry command queue.
//  The back end passes a read state before each payload beat: the event
//  buffer RAM has a registered read, one read per beat.
//  Reset clears all control state; buffer contents are not cleared and never
//  read before being written.
//  Either side stalls on its own: a slow sink holds the back end only, and
//  the front end keeps taking beats until it needs a bank still being sent.
//
module bus_event_packetizer_core import bep_pkg::*; #(
  parameter int unsigned MaxEvents = MAX_EVENTS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bep_in_t    in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output bep_out_t   out_item_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  // Two banks of event storage: one filling while the other drains.
  localparam int unsigned IdxW  = bep_idx_w(MaxEvents);
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned Depth = 2 ** AddrW;

  bep_cmd_t         cmd_push_data, cmd_head;
  logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
  bep_release_t     rel;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [EVT_W-1:0] ram_wdata, ram_rdata;

  // Front end: classifies beats, tracks the open packet, fills the buffer.
  bep_front #(.MaxEvents(MaxEvents)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_push_data),
    .cmd_full_i  (cmd_full),
    .rel_i       (rel),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  // Flush commands: at most two outstanding, one per bank.
  bep_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_push_data),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  bep_ram #(.Width(EVT_W), .Depth(Depth)) u_evt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back end: header then payload beats through a registered output stage.
  bep_back #(.MaxEvents(MaxEvents)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .rel_o       (rel),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> sv/bep_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bep_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bep_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Bus event packetizer command queue
// Short queue of flush commands between front and back end.
// ----------------------------------------------------------------------------
module bep_cmd_fifo import bep_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bep_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output bep_cmd_t cmd_o
);

  localparam int unsigned PtrW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_DEPTH + 1);

  bep_cmd_t          mem_q [CMD_DEPTH];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/bep_front.sv
// ----------------------------------------------------------------------------
// Bus event packetizer front end
// Takes input beats, keeps the open-packet state, stores events in the
// buffer bank and queues flush commands.
// ----------------------------------------------------------------------------
module bep_front import bep_pkg::*; #(
  parameter int unsigned MaxEvents = MAX_EVENTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bep_in_t                        in_item_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i,
  output logic                           cmd_push_o,
  output bep_cmd_t                       cmd_o,
  input  logic                           cmd_full_i,
  input  bep_release_t                   rel_i,
  output logic                           ram_we_o,
  output logic [bep_idx_w(MaxEvents):0]  ram_waddr_o,
  output logic [EVT_W-1:0]               ram_wdata_o
);

  localparam int unsigned IdxW  = bep_idx_w(MaxEvents);
  localparam int unsigned FillW = $clog2(MaxEvents + 1);

  typedef enum logic [1:0] {F_IDLE, F_PUSHF, F_WR, F_PUSHE} state_e;

  state_e           state_q;
  bep_in_t          item_q;
  logic [7:0]       channel_q, stop_q;
  logic             open_q, split_q, bank_q;
  logic [FillW-1:0] fill_q;
  logic [7:0]       pending_q, flags_q, chan_q;
  logic [31:0]      seq_q, time_q;
  logic [1:0]       busy_q;
  logic             push, write_ok;

  assign in_ready_o = (state_q == F_IDLE);
  assign cmd_push_o = (state_q == F_PUSHF) || (state_q == F_PUSHE);
  assign push       = cmd_push_o && !cmd_full_i;
  assign write_ok   = (state_q == F_WR) && !busy_q[bank_q];

  assign cmd_o.bank    = bank_q;
  assign cmd_o.seq     = seq_q;
  assign cmd_o.flags   = flags_q;
  assign cmd_o.channel = chan_q;
  assign cmd_o.count   = CNT_W'(fill_q);
  assign cmd_o.stamp   = time_q;

  assign ram_we_o    = write_ok;
  assign ram_waddr_o = {bank_q, fill_q[IdxW-1:0]};
  assign ram_wdata_o = {item_q.event_kind, item_q.event_data};

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  // A bank is held from its flush command until the back end has read it out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      for (int b = 0; b < 2; b++) begin
        busy_q[b] <= (busy_q[b] && !(rel_i.valid && (rel_i.bank == 1'(b))))
                     || (push && (bank_q == 1'(b)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      channel_q <= '0;
      stop_q    <= '0;
      open_q    <= 1'b0;
      split_q   <= 1'b0;
      bank_q    <= 1'b0;
      fill_q    <= '0;
      pending_q <= '0;
      flags_q   <= '0;
      chan_q    <= '0;
      seq_q     <= '0;
      time_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CHANNEL: channel_q <= cfg_wdata_i;
          REG_STOP:    stop_q    <= cfg_wdata_i;
          default:     ;
        endcase
      end
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            case (in_item_i.opcode)
              OP_MARK: pending_q <= pending_q | in_item_i.mark_bits;
              OP_DISCARD: begin
                split_q <= 1'b0;
                open_q  <= 1'b0;
                fill_q  <= '0;
              end
              OP_APPEND: begin
                if (!open_q) begin
                  // open a fresh packet
                  seq_q     <= seq_q + 32'd1;
                  time_q    <= in_item_i.time_now;
                  chan_q    <= channel_q;
                  flags_q   <= pending_q | (split_q ? FLAG_CONTINUED : 8'h00);
                  pending_q <= '0;
                  open_q    <= 1'b1;
                  state_q   <= F_WR;
                end else if (fill_q == FillW'(MaxEvents)) begin
                  if (in_item_i.sink_ready) begin
                    state_q <= F_PUSHF;
                  end else begin
                    // sink refused: packet and event are lost
                    split_q   <= 1'b0;
                    open_q    <= 1'b0;
                    fill_q    <= '0;
                    pending_q <= pending_q | FLAG_OVERFLOW;
                  end
                end else begin
                  state_q <= F_WR;
                end
              end
              default: ;
            endcase
          end
        end
        F_PUSHF: begin
          if (push) begin
            // full packet goes out, continuation opens in the other bank
            bank_q    <= ~bank_q;
            fill_q    <= '0;
            split_q   <= 1'b1;
            seq_q     <= seq_q + 32'd1;
            time_q    <= item_q.time_now;
            chan_q    <= channel_q;
            flags_q   <= pending_q | FLAG_CONTINUED;
            pending_q <= '0;
            state_q   <= F_WR;
          end
        end
        F_WR: begin
          if (write_ok) begin
            if (item_q.event_kind == stop_q) begin
              if (item_q.sink_ready) begin
                fill_q  <= fill_q + FillW'(1);
                flags_q <= flags_q | FLAG_END;
                state_q <= F_PUSHE;
              end else begin
                split_q   <= 1'b0;
                open_q    <= 1'b0;
                fill_q    <= '0;
                pending_q <= pending_q | FLAG_OVERFLOW;
                state_q   <= F_IDLE;
              end
            end else begin
              fill_q  <= fill_q + FillW'(1);
              state_q <= F_IDLE;
            end
          end
        end
        F_PUSHE: begin
          if (push) begin
            bank_q  <= ~bank_q;
            open_q  <= 1'b0;
            fill_q  <= '0;
            split_q <= 1'b0;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bep_back.sv
// ----------------------------------------------------------------------------
// Bus event packetizer back end
// Turns one flush command into a header beat and one payload beat per event.
// ----------------------------------------------------------------------------
module bep_back import bep_pkg::*; #(
  parameter int unsigned MaxEvents = MAX_EVENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  bep_cmd_t                      cmd_i,
  output logic                          cmd_pop_o,
  output bep_release_t                  rel_o,
  output logic                          ram_re_o,
  output logic [bep_idx_w(MaxEvents):0] ram_raddr_o,
  input  logic [EVT_W-1:0]              ram_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bep_out_t                      out_item_o
);

  localparam int unsigned IdxW = bep_idx_w(MaxEvents);

  typedef enum logic [1:0] {B_IDLE, B_HDR, B_RD, B_PAY} state_e;

  state_e          state_q;
  bep_out_t        out_q;
  logic            out_valid_q;
  logic [IdxW-1:0] idx_q, idx_nxt;
  logic            done;

  assign done        = (state_q == B_PAY) && out_ready_i && out_q.last;
  assign cmd_pop_o   = done;
  assign rel_o.valid = done;
  assign rel_o.bank  = cmd_i.bank;

  assign idx_nxt     = (state_q == B_HDR) ? '0 : idx_q + IdxW'(1);
  assign ram_re_o    = out_ready_i && ((state_q == B_HDR)
                                       || ((state_q == B_PAY) && !out_q.last));
  assign ram_raddr_o = {cmd_i.bank, idx_nxt};

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      idx_q       <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (cmd_valid_i) begin
            out_q.item_kind        <= KIND_HEADER;
            out_q.last             <= (cmd_i.count == '0);
            out_q.seq_number       <= cmd_i.seq;
            out_q.header_flags     <= cmd_i.flags;
            out_q.channel_out      <= cmd_i.channel;
            out_q.events_in_packet <= cmd_i.count[4:0];
            out_q.packet_time      <= cmd_i.stamp;
            out_q.out_event_kind   <= '0;
            out_q.out_event_data   <= '0;
            out_valid_q            <= 1'b1;
            state_q                <= B_HDR;
          end
        end
        B_HDR: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            idx_q       <= idx_nxt;
            state_q     <= B_RD;
          end
        end
        B_RD: begin
          // read data for idx_q is on the RAM output now
          out_q.item_kind      <= KIND_EVENT;
          out_q.last           <= (CNT_W'(idx_q) + CNT_W'(1) == cmd_i.count);
          out_q.out_event_kind <= ram_rdata_i[15:8];
          out_q.out_event_data <= ram_rdata_i[7:0];
          out_valid_q          <= 1'b1;
          state_q              <= B_PAY;
        end
        B_PAY: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_q.last) begin
              state_q <= B_IDLE;
            end else begin
              idx_q   <= idx_nxt;
              state_q <= B_RD;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bep_checker.sv
// ----------------------------------------------------------------------------
// Bus event packetizer checker
// Port-level checks on the output stream and input acceptance.
// ----------------------------------------------------------------------------
`include "bus_event_packetizer_core_assert.svh"

module bep_checker import bep_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input bep_in_t  in_item_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input bep_out_t out_item_i
);

  `BEP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "output beat dropped or changed while stalled")
  `BEP_ASSERT_IMPL(a_hdr_not_last, out_valid_i && (out_item_i.item_kind == KIND_HEADER), !out_item_i.last, "header beat flagged last")
  `BEP_ASSERT_NEXT(a_out_gap, out_valid_i && out_ready_i, !out_valid_i, "output stage reloaded in the cycle after a beat")
  `BEP_ASSERT_NEXT(a_ctl_single, in_valid_i && in_ready_i && (in_item_i.opcode != OP_APPEND), in_ready_i, "non-append beat held the front end")

endmodule

bind bus_event_packetizer_core bep_checker u_bep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

>>> tb/bus_event_packetizer_core_tb.sv
// ----------------------------------------------------------------------------
// Bus event packetizer core testbench
// Drives bus events, marks and discards into the packetizer under random
// sender gaps and sink stalls, and checks every header and payload beat
// against a cycle-free model of the packing rules kept in this file.
// ----------------------------------------------------------------------------
module bus_event_packetizer_core_tb;
  import bep_pkg::*;

  // Opcode 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Generous bound: a few hundred items at worst 17 beats each, each beat
  // waiting out sink stalls, plus one long deliberate hold-off.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Lets the front end finish its last item and the command queue drain;
  // a mark or discard beat produces no output, so allow it to settle.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  bep_in_t    in_item;
  logic       out_valid;
  logic       out_ready;
  bep_out_t   out_item;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;

  bus_event_packetizer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // 12 time unit period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Packing model: own copy of configuration and packet state
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_channel;
  logic [7:0]  cfg_stop;
  logic        pkt_open;
  logic [4:0]  pkt_fill;
  logic        pkt_split;
  logic [7:0]  next_flags;
  logic [31:0] seq_count;
  logic [7:0]  pkt_flags;
  logic [31:0] pkt_stamp;
  logic [7:0]  pkt_channel;
  logic [15:0] event_buf [MAX_EVENTS];

  bep_out_t expected_beats_q [$];

  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  // Sender burst control and receiver hold-off request.
  bit          gaps_on;
  int unsigned burst_left;
  int unsigned hold_req;

  function automatic void open_new_packet(input logic [31:0] stamp);
    seq_count   = seq_count + 32'd1;
    pkt_stamp   = stamp;
    pkt_channel = cfg_channel;
    pkt_flags   = next_flags;
    if (pkt_split) pkt_flags |= FLAG_CONTINUED;
    next_flags = '0;
    pkt_open   = 1'b1;
  endfunction

  // Queues the beats of the open packet; 0 if the sink refused it.
  function automatic bit flush_open_packet(input bit is_end, input bit sink_ok);
    bep_out_t beat;
    int       i;
    if (!pkt_open) return 1'b1;
    if (is_end) pkt_flags |= FLAG_END;
    if (!sink_ok) begin
      pkt_split  = 1'b0;
      pkt_open   = 1'b0;
      pkt_fill   = '0;
      next_flags = next_flags | FLAG_OVERFLOW;
      return 1'b0;
    end
    beat                  = '0;
    beat.item_kind        = KIND_HEADER;
    beat.last             = (pkt_fill == 0);
    beat.seq_number       = seq_count;
    beat.header_flags     = pkt_flags;
    beat.channel_out      = pkt_channel;
    beat.events_in_packet = pkt_fill;
    beat.packet_time      = pkt_stamp;
    expected_beats_q.push_back(beat);
    for (i = 0; i < pkt_fill; i++) begin
      beat.item_kind      = KIND_EVENT;
      beat.last           = (i + 1 == pkt_fill);
      beat.out_event_kind = event_buf[i][15:8];
      beat.out_event_data = event_buf[i][7:0];
      expected_beats_q.push_back(beat);
    end
    pkt_open  = 1'b0;
    pkt_fill  = '0;
    pkt_split = !is_end;
    return 1'b1;
  endfunction

  function automatic void packetize_beat(input bep_in_t b);
    case (b.opcode)
      OP_MARK: begin
        next_flags = next_flags | b.mark_bits;
      end
      OP_DISCARD: begin
        pkt_split = 1'b0;
        pkt_open  = 1'b0;
        pkt_fill  = '0;
      end
      OP_APPEND: begin
        if (!pkt_open) open_new_packet(b.time_now);
        // Full packet: flush without end, reopen; a refusal loses the event.
        if (pkt_fill >= MAX_EVENTS) begin
          if (!flush_open_packet(1'b0, b.sink_ready)) return;
          open_new_packet(b.time_now);
        end
        if (pkt_fill < MAX_EVENTS) begin
          event_buf[pkt_fill] = {b.event_kind, b.event_data};
          pkt_fill++;
        end
        if (b.event_kind == cfg_stop) void'(flush_open_packet(1'b1, b.sink_ready));
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic bep_in_t make_beat(input logic [1:0] op, input logic [7:0] kind);
    bep_in_t b;
    b.opcode     = op;
    b.event_kind = kind;
    b.event_data = 8'($urandom_range(0, 255));
    b.mark_bits  = 8'($urandom_range(0, 255));
    b.time_now   = $urandom;
    b.sink_ready = ($urandom_range(0, 9) != 0);
    return b;
  endfunction

  // Any event kind except the current stop code.
  function automatic logic [7:0] plain_kind();
    logic [7:0] k;
    k = 8'($urandom_range(0, 255));
    if (k == cfg_stop) k = k ^ 8'h01;
    return k;
  endfunction

  // One beat on the input channel. Between bursts valid drops for a random
  // gap; within a burst it stays high across back-to-back beats.
  task automatic send_beat(input bep_in_t b);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = b;
    do @(posedge clk); while (!in_ready);
    packetize_beat(b);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_CHANNEL) cfg_channel = value;
    else cfg_stop = value;
  endtask

  // Stop offering, wait for every expected beat, then let the front end
  // finish any beat that produces no output.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Each opcode, field extremes, stop flush, discard, refused sink.
  task automatic test_basic_ops();
    bep_in_t b;
    write_reg(REG_CHANNEL, 8'hFF);
    write_reg(REG_STOP, 8'h00);
    b = make_beat(OP_MARK, 8'h00);      b.mark_bits = 8'hF8;            send_beat(b);
    b = make_beat(OP_UNUSED, 8'h00);                                    send_beat(b);
    b = make_beat(OP_APPEND, 8'h80);    b.event_data = 8'h00;
    b.time_now = 32'h0000_0000;                                         send_beat(b);
    b = make_beat(OP_APPEND, 8'hFF);    b.event_data = 8'hFF;
    b.time_now = 32'hFFFF_FFFF;                                         send_beat(b);
    b = make_beat(OP_APPEND, 8'h00);    b.sink_ready = 1'b1;            send_beat(b);
    b = make_beat(OP_APPEND, 8'h01);                                    send_beat(b);
    b = make_beat(OP_DISCARD, 8'h00);                                   send_beat(b);
    b = make_beat(OP_APPEND, 8'h33);                                    send_beat(b);
    // Refused flush: packet lost, overflow flagged on the next one.
    b = make_beat(OP_APPEND, 8'h00);    b.sink_ready = 1'b0;            send_beat(b);
    b = make_beat(OP_MARK, 8'h00);      b.mark_bits = 8'h03;            send_beat(b);
    b = make_beat(OP_APPEND, 8'h00);    b.sink_ready = 1'b1;            send_beat(b);
  endtask

  // Sixteen events fill the buffer; the seventeenth splits the packet and
  // the follow-on packet carries the continued flag.
  task automatic test_full_packet();
    bep_in_t b;
    int      i;
    wait_idle();
    write_reg(REG_CHANNEL, 8'h00);
    write_reg(REG_STOP, 8'hFF);
    for (i = 0; i <= MAX_EVENTS; i++) begin
      b = make_beat(OP_APPEND, 8'(i));
      b.sink_ready = 1'b1;
      send_beat(b);
    end
    b = make_beat(OP_APPEND, 8'hFF);
    b.sink_ready = 1'b1;
    send_beat(b);
  endtask

  // Random traffic under several register settings, extremes included.
  // Mostly complete packets ending in the stop code; the rest is noise.
  task automatic test_config_sweep();
    bep_in_t     b;
    int          phase;
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    int unsigned j;
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(REG_CHANNEL, 8'($urandom_range(1, 254)));
          write_reg(REG_STOP, 8'($urandom_range(1, 254)));
        end
        1: begin
          write_reg(REG_CHANNEL, 8'hFF);
          write_reg(REG_STOP, 8'h00);
        end
        2: begin
          write_reg(REG_CHANNEL, 8'h00);
          write_reg(REG_STOP, 8'hFF);
        end
        default: begin
          write_reg(REG_STOP, 8'($urandom_range(0, 255)));
          write_reg(REG_CHANNEL, 8'($urandom_range(0, 255)));
        end
      endcase
      gaps_on = (phase != 2);
      sent    = 0;
      while (sent < 30) begin
        if ($urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 4) == 0) begin
            send_beat(make_beat(OP_MARK, 8'($urandom_range(0, 255))));
            sent++;
          end
          r = $urandom_range(0, 19);
          if (r < 14)      len = $urandom_range(1, 5);
          else if (r < 17) len = $urandom_range(6, MAX_EVENTS);
          else             len = $urandom_range(MAX_EVENTS + 1, MAX_EVENTS + 4);
          for (j = 0; j < len; j++) begin
            b = make_beat(OP_APPEND, plain_kind());
            // Refusal on the splitting beat is otherwise rare.
            if (j == MAX_EVENTS && $urandom_range(0, 1) == 0) b.sink_ready = 1'b0;
            send_beat(b);
            sent++;
          end
          send_beat(make_beat(OP_APPEND, cfg_stop));
          sent++;
        end else begin
          send_beat(make_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
          sent++;
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Sink held off for a long stretch while short packets keep arriving
  // back to back, so both banks fill and the input stalls.
  task automatic test_backpressure();
    bep_in_t     b;
    int unsigned k;
    int unsigned j;
    wait_idle();
    gaps_on = 1'b0;
    b = make_beat(OP_APPEND, plain_kind());
    send_beat(b);
    hold_req = HOLD_CYCLES;
    for (k = 0; k < 12; k++) begin
      for (j = 0; j < $urandom_range(2, 4); j++) begin
        b = make_beat(OP_APPEND, plain_kind());
        b.sink_ready = 1'b1;
        send_beat(b);
      end
      b = make_beat(OP_APPEND, cfg_stop);
      b.sink_ready = 1'b1;
      send_beat(b);
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: long hold-off on request, else a stall pattern redrawn each time
  // it runs out (always ready, random bits, mostly ready, mostly stalled).
  // --------------------------------------------------------------------------
  int unsigned hold_cnt;
  int unsigned pat_left;
  int unsigned pat_mode;
  logic [31:0] pat_bits;
  logic [31:0] pat_mask;

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_bits = $urandom;
        pat_mask = $urandom;
        pat_mode = $urandom_range(0, 3);
        pat_left = 32;
      end
      pat_left--;
      case (pat_mode)
        0:       out_ready = 1'b1;
        1:       out_ready = pat_bits[pat_left];
        2:       out_ready = pat_bits[pat_left] | pat_mask[pat_left];
        default: out_ready = pat_bits[pat_left] & pat_mask[pat_left];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output checker: each accepted beat against the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bep_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected output beat %h", out_item);
      end else begin
        want = expected_beats_q.pop_front();
        check_field("item_kind",        32'(want.item_kind),        32'(out_item.item_kind));
        check_field("last",             32'(want.last),             32'(out_item.last));
        check_field("seq_number",       want.seq_number,            out_item.seq_number);
        check_field("header_flags",     32'(want.header_flags),     32'(out_item.header_flags));
        check_field("channel_out",      32'(want.channel_out),      32'(out_item.channel_out));
        check_field("events_in_packet", 32'(want.events_in_packet),
                    32'(out_item.events_in_packet));
        check_field("packet_time",      want.packet_time,           out_item.packet_time);
        check_field("out_event_kind",   32'(want.out_event_kind),   32'(out_item.out_event_kind));
        check_field("out_event_data",   32'(want.out_event_data),   32'(out_item.out_event_data));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bus_event_packetizer_core_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_CHANNEL;
    cfg_wdata    = '0;
    cfg_channel  = '0;
    cfg_stop     = '0;
    pkt_open     = 1'b0;
    pkt_fill     = '0;
    pkt_split    = 1'b0;
    next_flags   = '0;
    seq_count    = '0;
    pkt_flags    = '0;
    pkt_stamp    = '0;
    pkt_channel  = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    hold_req     = 0;
    hold_cnt     = 0;
    pat_left     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_full_packet();
    test_config_sweep();
    test_backpressure();
    wait_idle();

    if (mismatch_cnt == 0 && expected_beats_q.size() == 0) begin
      $display("bus_event_packetizer_core_tb: PASS");
    end else begin
      $display("bus_event_packetizer_core_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> bus_event_packetizer_core.f
+incdir+sv
sv/bep_pkg.sv
sv/bep_ram.sv
sv/bep_cmd_fifo.sv
sv/bep_front.sv
sv/bep_back.sv
sv/bus_event_packetizer_core.sv
sv/bep_checker.sv
tb/bus_event_packetizer_core_tb.sv
